/* design/oukt_pkg.sv */
`default_nettype none

package oukt_pkg;

   localparam int DEPTH_DEFAULT = 16;

   localparam int FUNC_W    = 2;
   localparam int KEY_W     = 32;
   localparam int MARKS_W   = 16;
   localparam int POS_W     = 4;
   localparam int STATUS_W  = 3;
   localparam int FIDX_W    = 4;
   localparam int ENTRY_W   = 5;

   localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_FIND   = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_READ   = 2'd3;

   localparam logic [STATUS_W-1:0] STATUS_OK       = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_NOTFOUND = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_DUP      = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_FULL     = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_RANGE    = 3'd4;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'b01,
      ST_APPLY = 2'b10
   } fsm_state_type;

   typedef struct packed {
      logic [KEY_W-1:0]   key;
      logic [MARKS_W-1:0] marks;
      logic               compare;
      logic               append;
      logic               remove;
   } cell_cmd_type;

endpackage

`default_nettype wire

/* design/oukt_cell.sv */
`default_nettype none

module oukt_cell #(
   parameter int CELL_IDX = 0,
   parameter int CNT_W    = 5
) (
   input  wire logic                          clock,
   input  wire oukt_pkg::cell_cmd_type        cmd,
   input  wire logic [CNT_W-1:0]              count,
   input  wire logic                          seen_in,
   input  wire logic [oukt_pkg::KEY_W-1:0]    next_key,
   input  wire logic [oukt_pkg::MARKS_W-1:0]  next_marks,
   output logic                               match,
   output logic                               seen_out,
   output logic [oukt_pkg::KEY_W-1:0]         key_out,
   output logic [oukt_pkg::MARKS_W-1:0]       marks_out
);
   import oukt_pkg::*;

   logic [KEY_W-1:0]   key_ff;
   logic [KEY_W-1:0]   key_in;
   logic [MARKS_W-1:0] marks_ff;
   logic [MARKS_W-1:0] marks_in;
   logic               match_ff;
   logic               match_in;
   logic               valid;
   logic               append;
   logic               shift;

   assign valid    = count > CNT_W'(CELL_IDX);
   assign append   = cmd.append && (count == CNT_W'(CELL_IDX));
   assign seen_out = seen_in | match_ff;
   assign shift    = cmd.remove && seen_out;

   always_comb begin
      match_in = match_ff;
      if (cmd.compare) begin
         match_in = valid && (key_ff == cmd.key);
      end
   end

   always_comb begin
      key_in   = key_ff;
      marks_in = marks_ff;
      if (append) begin
         key_in   = cmd.key;
         marks_in = cmd.marks;
      end else if (shift) begin
         key_in   = next_key;
         marks_in = next_marks;
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      marks_ff <= marks_in;
      match_ff <= match_in;
   end

   assign match     = match_ff;
   assign key_out   = key_ff;
   assign marks_out = marks_ff;

endmodule

`default_nettype wire

/* design/ordered_unique_key_table.sv */
// Channel   Ports                                     Handshake
// --------  ----------------------------------------  --------------------------------
// request   req_func req_key req_marks req_position   taken when start && !busy
// response  rsp_status rsp_found_index rsp_key_out    one-cycle strobe on rsp_valid
//           rsp_marks_out rsp_entry_total
//
// An item takes two cycles: in the cycle it is taken every cell compares its key,
// and in the next cycle (busy high) the row appends, shifts down or is read.
// The result strobes in the cycle after that, and a new item may be taken then,
// so one item every two cycles; the compare-then-apply pass over the cell row
// sets this figure. Synchronous reset empties the table. The receiver cannot stall.
`default_nettype none

module ordered_unique_key_table #(
   parameter int DEPTH = oukt_pkg::DEPTH_DEFAULT
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 start,
   output logic                                      busy,
   input  wire logic [oukt_pkg::FUNC_W-1:0]          req_func,
   input  wire logic signed [oukt_pkg::KEY_W-1:0]    req_key,
   input  wire logic [oukt_pkg::MARKS_W-1:0]         req_marks,
   input  wire logic [oukt_pkg::POS_W-1:0]           req_position,
   output logic                                      rsp_valid,
   output logic [oukt_pkg::STATUS_W-1:0]             rsp_status,
   output logic [oukt_pkg::FIDX_W-1:0]               rsp_found_index,
   output logic signed [oukt_pkg::KEY_W-1:0]         rsp_key_out,
   output logic [oukt_pkg::MARKS_W-1:0]              rsp_marks_out,
   output logic [oukt_pkg::ENTRY_W-1:0]              rsp_entry_total
);
   import oukt_pkg::*;

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int IW    = $clog2(DEPTH);
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
   localparam int RD_N  = (DEPTH < (1 << POS_W)) ? DEPTH : (1 << POS_W);

   fsm_state_type state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [FUNC_W-1:0]  func_ff;
   logic [KEY_W-1:0]   key_ff;
   logic [MARKS_W-1:0] marks_ff;
   logic [POS_W-1:0]   pos_ff;

   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [FIDX_W-1:0]   fidx_ff, fidx_in;
   logic [KEY_W-1:0]    key_out_ff, key_out_in;
   logic [MARKS_W-1:0]  marks_out_ff, marks_out_in;
   logic [ENTRY_W-1:0]  total_ff;

   logic                accept;
   logic                apply;
   logic                hit;
   logic                full;
   logic                pos_ok;
   logic [IW-1:0]       at_idx;
   logic [IW+FIDX_W-1:0]    at_wide;
   logic [CNT_W+ENTRY_W-1:0] total_wide;
   logic [KEY_W-1:0]    rd_key;
   logic [MARKS_W-1:0]  rd_marks;
   cell_cmd_type        cmd;

   logic [DEPTH:0]      seen_chain;
   logic [DEPTH-1:0]    cell_match;
   logic [KEY_W-1:0]    cell_key   [DEPTH];
   logic [MARKS_W-1:0]  cell_marks [DEPTH];

   assign busy   = (state_ff == ST_APPLY);
   assign accept = start && !busy;
   assign apply  = busy;
   assign hit    = seen_chain[DEPTH];
   assign full   = (count_ff == CNT_W'(DEPTH));

   always_comb begin
      cmd.key     = apply ? key_ff : req_key;
      cmd.marks   = marks_ff;
      cmd.compare = accept;
      cmd.append  = apply && (func_ff == FUNC_INSERT) && !hit && !full;
      cmd.remove  = apply && (func_ff == FUNC_REMOVE) && hit;
   end

   assign seen_chain[0] = 1'b0;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [KEY_W-1:0]   nxt_key;
      logic [MARKS_W-1:0] nxt_marks;
      if (i == DEPTH - 1) begin : g_last
         assign nxt_key   = cell_key[i];
         assign nxt_marks = cell_marks[i];
      end else begin : g_mid
         assign nxt_key   = cell_key[i+1];
         assign nxt_marks = cell_marks[i+1];
      end
      oukt_cell #(
         .CELL_IDX (i),
         .CNT_W    (CNT_W)
      ) u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .count      (count_ff),
         .seen_in    (seen_chain[i]),
         .next_key   (nxt_key),
         .next_marks (nxt_marks),
         .match      (cell_match[i]),
         .seen_out   (seen_chain[i+1]),
         .key_out    (cell_key[i]),
         .marks_out  (cell_marks[i])
      );
   end

   always_comb begin
      at_idx = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (cell_match[i]) begin
            at_idx = at_idx | IW'(i);
         end
      end
   end

   assign pos_ok = CMP_W'(pos_ff) < CMP_W'(count_ff);

   always_comb begin
      rd_key   = '0;
      rd_marks = '0;
      for (int i = 0; i < RD_N; i++) begin
         if (pos_ff == POS_W'(i)) begin
            rd_key   = cell_key[i];
            rd_marks = cell_marks[i];
         end
      end
   end

   assign at_wide = {{FIDX_W{1'b0}}, at_idx};

   always_comb begin
      status_in    = STATUS_OK;
      fidx_in      = '0;
      key_out_in   = '0;
      marks_out_in = '0;
      count_in     = count_ff;
      case (func_ff)
         FUNC_INSERT: begin
            if (hit) begin
               status_in = STATUS_DUP;
            end else if (full) begin
               status_in = STATUS_FULL;
            end else begin
               count_in = count_ff + CNT_W'(1);
            end
         end
         FUNC_REMOVE: begin
            if (hit) begin
               count_in = count_ff - CNT_W'(1);
            end else begin
               status_in = STATUS_NOTFOUND;
            end
         end
         FUNC_FIND: begin
            if (hit) begin
               fidx_in = at_wide[FIDX_W-1:0];
            end else begin
               status_in = STATUS_NOTFOUND;
            end
         end
         FUNC_READ: begin
            if (pos_ok) begin
               key_out_in   = rd_key;
               marks_out_in = rd_marks;
            end else begin
               status_in = STATUS_RANGE;
            end
         end
         default: begin
            status_in = STATUS_OK;
         end
      endcase
   end

   assign total_wide = {{ENTRY_W{1'b0}}, count_in};

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_APPLY;
            end
         end
         ST_APPLY: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= apply;
         if (apply) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff  <= req_func;
         key_ff   <= req_key;
         marks_ff <= req_marks;
         pos_ff   <= req_position;
      end
      if (apply) begin
         status_ff    <= status_in;
         fidx_ff      <= fidx_in;
         key_out_ff   <= key_out_in;
         marks_out_ff <= marks_out_in;
         total_ff     <= total_wide[ENTRY_W-1:0];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_found_index = fidx_ff;
   assign rsp_key_out     = key_out_ff;
   assign rsp_marks_out   = marks_out_ff;
   assign rsp_entry_total = total_ff;

   a_apply_one_cycle: assert property (@(posedge clock) disable iff (reset)
      busy |=> !busy)
      else $error("apply lasted more than one cycle");

   a_accept_to_apply: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("accepted item did not reach apply");

   a_rsp_after_apply: assert property (@(posedge clock) disable iff (reset)
      busy |=> rsp_valid)
      else $error("no result after apply");

   a_rsp_only_after_apply: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result strobe without apply");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count above depth");

endmodule

`default_nettype wire
